// ----- sv/lc3ie_pkg.sv -----
`default_nettype none
package lc3ie_pkg;
    localparam int ADDR_WIDTH_DEF = 16;
    localparam logic [15:0] START_PC_RESET = 16'h3000;

    localparam logic [1:0] KIND_EXEC    = 2'd0;
    localparam logic [1:0] KIND_PRELOAD = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_RES  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic [2:0] CC_N = 3'd4;
    localparam logic [2:0] CC_Z = 3'd2;
    localparam logic [2:0] CC_P = 3'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] instruction;
        logic [15:0] load_addr;
        logic [15:0] load_data;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pc_after;
        logic [2:0]  cond_flags;
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [15:0] reg_value;
        logic        mem_written;
        logic [15:0] store_addr;
        logic [15:0] store_data;
        logic        unsupported;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_DONE
    } state_t;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        if (v == 16'd0)
            return CC_Z;
        else if (v[15])
            return CC_N;
        else
            return CC_P;
    endfunction
endpackage
`default_nettype wire

// ----- sv/lc3ie_mem.sv -----
`default_nettype none
module lc3ie_mem #(
    parameter int ADDR_WIDTH = lc3ie_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [ADDR_WIDTH-1:0] waddr,
    input  wire logic [15:0]           wdata,
    input  wire logic [ADDR_WIDTH-1:0] raddr,
    output logic      [15:0]           rdata
);
    logic [15:0] mem [2**ADDR_WIDTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/lc3_instruction_execute_top.sv -----
`default_nettype none
// lc3 execute unit: one word in, one result word out per item. registers, pc and flags
// live in flip-flops, the word memory is one synchronous ram with one write and one
// read port. preload, restart, alu ops, branches, jumps, pc-relative/base stores and
// unsupported opcodes complete from the idle state; ld, ldr and sti pass through rd1
// (one memory read); ldi passes through rd1 and rd2 (two dependent memory reads). a new
// word is taken whenever no load or indirect store is in progress and the result
// register is free or being drained in the same cycle.
module lc3_instruction_execute_top #(
    parameter int ADDR_WIDTH = lc3ie_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lc3ie_pkg::in_word_t  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lc3ie_pkg::out_word_t      out_data
);
    lc3ie_pkg::state_t state_reg, state_next;
    logic [15:0] start_pc_reg;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic [15:0] gpr_reg [8];
    logic [15:0] ins_reg, ins_next;
    logic        out_valid_reg, out_valid_next;
    lc3ie_pkg::out_word_t out_reg, out_next;

    // memory port wiring
    logic                  mem_we;
    logic [ADDR_WIDTH-1:0] mem_waddr, mem_raddr;
    logic [15:0]           mem_wdata, mem_rdata;

    logic        gpr_we;
    logic [2:0]  gpr_idx;
    logic [15:0] gpr_val;

    lc3ie_mem #(.ADDR_WIDTH(ADDR_WIDTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // decode of the word in flight: input word when idle, held word later
    logic [15:0] ins;
    logic [3:0]  op;
    logic [2:0]  dr, r1, r2;
    logic [15:0] off9, off6, imm5, off11, pc_inc, pc_off9, base_off6, src2;

    assign ins       = (state_reg == lc3ie_pkg::ST_IDLE) ? in_data.instruction : ins_reg;
    assign op        = ins[15:12];
    assign dr        = ins[11:9];
    assign r1        = ins[8:6];
    assign r2        = ins[2:0];
    assign off9      = {{7{ins[8]}}, ins[8:0]};
    assign off6      = {{10{ins[5]}}, ins[5:0]};
    assign imm5      = {{11{ins[4]}}, ins[4:0]};
    assign off11     = {{5{ins[10]}}, ins[10:0]};
    // in later states pc_reg already holds the incremented pc
    assign pc_inc    = (state_reg == lc3ie_pkg::ST_IDLE) ? pc_reg + 16'd1 : pc_reg;
    assign pc_off9   = pc_inc + off9;
    assign base_off6 = gpr_reg[r1] + off6;
    assign src2      = ins[5] ? imm5 : gpr_reg[r2];

    logic out_free;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == lc3ie_pkg::ST_IDLE) && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cc_next        = cc_reg;
        ins_next       = ins_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mem_we         = 1'b0;
        mem_waddr      = in_data.load_addr[ADDR_WIDTH-1:0];
        mem_wdata      = in_data.load_data;
        mem_raddr      = pc_off9[ADDR_WIDTH-1:0];
        gpr_we         = 1'b0;
        gpr_idx        = dr;
        gpr_val        = 16'd0;

        // default result fields
        case (state_reg)
            lc3ie_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    out_next             = '0;
                    ins_next             = in_data.instruction;
                    case (in_data.kind)
                        lc3ie_pkg::KIND_PRELOAD:
                        begin
                            mem_we = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        lc3ie_pkg::KIND_RESTART:
                        begin
                            pc_next = start_pc_reg;
                            out_valid_next = 1'b1;
                        end
                        lc3ie_pkg::KIND_EXEC:
                        begin
                            pc_next = pc_inc;
                            out_valid_next = 1'b1;
                            case (op)
                                lc3ie_pkg::OP_BR:
                                    if ((dr & cc_reg) != 3'd0)
                                        pc_next = pc_off9;
                                lc3ie_pkg::OP_ADD, lc3ie_pkg::OP_AND, lc3ie_pkg::OP_NOT,
                                lc3ie_pkg::OP_LEA:
                                begin
                                    case (op)
                                        lc3ie_pkg::OP_ADD: gpr_val = gpr_reg[r1] + src2;
                                        lc3ie_pkg::OP_AND: gpr_val = gpr_reg[r1] & src2;
                                        lc3ie_pkg::OP_NOT: gpr_val = ~gpr_reg[r1];
                                        default:           gpr_val = pc_off9;
                                    endcase
                                    gpr_we = 1'b1;
                                    cc_next = lc3ie_pkg::flags_of(gpr_val);
                                    out_next.reg_written = 1'b1;
                                    out_next.reg_index = dr;
                                    out_next.reg_value = gpr_val;
                                end
                                lc3ie_pkg::OP_JMP:
                                    pc_next = gpr_reg[r1];
                                lc3ie_pkg::OP_JSR:
                                begin
                                    pc_next = ins[11] ? pc_inc + off11 : gpr_reg[r1];
                                    gpr_we = 1'b1;
                                    gpr_idx = 3'd7;
                                    gpr_val = pc_inc;
                                    out_next.reg_written = 1'b1;
                                    out_next.reg_index = 3'd7;
                                    out_next.reg_value = pc_inc;
                                end
                                lc3ie_pkg::OP_ST, lc3ie_pkg::OP_STR:
                                begin
                                    mem_we = 1'b1;
                                    mem_wdata = gpr_reg[dr];
                                    out_next.mem_written = 1'b1;
                                    out_next.store_addr =
                                        (op == lc3ie_pkg::OP_ST) ? pc_off9 : base_off6;
                                    out_next.store_data = gpr_reg[dr];
                                    mem_waddr = out_next.store_addr[ADDR_WIDTH-1:0];
                                end
                                lc3ie_pkg::OP_LD, lc3ie_pkg::OP_LDI, lc3ie_pkg::OP_STI:
                                begin
                                    mem_raddr = pc_off9[ADDR_WIDTH-1:0];
                                    out_valid_next = 1'b0;
                                    state_next = lc3ie_pkg::ST_RD1;
                                end
                                lc3ie_pkg::OP_LDR:
                                begin
                                    mem_raddr = base_off6[ADDR_WIDTH-1:0];
                                    out_valid_next = 1'b0;
                                    state_next = lc3ie_pkg::ST_RD1;
                                end
                                default:
                                    out_next.unsupported = 1'b1;
                            endcase
                        end
                        default:
                            out_valid_next = 1'b1;
                    endcase
                    out_next.pc_after   = pc_next;
                    out_next.cond_flags = cc_next;
                end
            end
            lc3ie_pkg::ST_RD1:
            begin
                // first read word is in mem_rdata
                case (op)
                    lc3ie_pkg::OP_LDI:
                    begin
                        mem_raddr = mem_rdata[ADDR_WIDTH-1:0];
                        state_next = lc3ie_pkg::ST_RD2;
                    end
                    lc3ie_pkg::OP_STI:
                    begin
                        mem_we = 1'b1;
                        mem_waddr = mem_rdata[ADDR_WIDTH-1:0];
                        mem_wdata = gpr_reg[dr];
                        out_next.mem_written = 1'b1;
                        out_next.store_addr = mem_rdata;
                        out_next.store_data = gpr_reg[dr];
                        out_valid_next = 1'b1;
                        state_next = lc3ie_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        gpr_we = 1'b1;
                        gpr_val = mem_rdata;
                        cc_next = lc3ie_pkg::flags_of(mem_rdata);
                        out_next.reg_written = 1'b1;
                        out_next.reg_index = dr;
                        out_next.reg_value = mem_rdata;
                        out_next.cond_flags = cc_next;
                        out_valid_next = 1'b1;
                        state_next = lc3ie_pkg::ST_IDLE;
                    end
                endcase
            end
            lc3ie_pkg::ST_RD2:
            begin
                gpr_we = 1'b1;
                gpr_val = mem_rdata;
                cc_next = lc3ie_pkg::flags_of(mem_rdata);
                out_next.reg_written = 1'b1;
                out_next.reg_index = dr;
                out_next.reg_value = mem_rdata;
                out_next.cond_flags = cc_next;
                out_valid_next = 1'b1;
                state_next = lc3ie_pkg::ST_IDLE;
            end
            default:
                state_next = lc3ie_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lc3ie_pkg::ST_IDLE;
            start_pc_reg  <= lc3ie_pkg::START_PC_RESET;
            pc_reg        <= lc3ie_pkg::START_PC_RESET;
            cc_reg        <= lc3ie_pkg::CC_Z;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                gpr_reg[i] <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cc_reg        <= cc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                start_pc_reg <= cfg_wdata;
            if (gpr_we)
                gpr_reg[gpr_idx] <= gpr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg <= ins_next;
        out_reg <= out_next;
    end

    // a multi-cycle load or store never runs while the result register is full
    a_busy_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lc3ie_pkg::ST_IDLE) |-> !out_valid_reg)
        else $error("result pending during multi-cycle item");
    // second read only follows an indirect load
    a_rd2_after_rd1: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lc3ie_pkg::ST_RD2) |-> $past(state_reg) == lc3ie_pkg::ST_RD1)
        else $error("second read without first");
    // condition code stays one-hot
    a_cc_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(cc_reg))
        else $error("condition code not one-hot");
endmodule
`default_nettype wire
